// ----- hdl/ready_queue_priority_insert_core_assert.svh -----
// Assertion macros for the ready queue core and its checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef READY_QUEUE_PRIORITY_INSERT_CORE_ASSERT_SVH
`define READY_QUEUE_PRIORITY_INSERT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RQPI_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rqpi: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RQPI_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rqpi: next-cycle check failed");

`endif

// ----- hdl/rqpi_pkg.sv -----
// Shared types and codes for the ready queue core.
// No dependencies; used by the core, its checker and the testbench.
package rqpi_pkg;

  // Item kinds
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_POP    = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  process_id;
    logic [15:0] priority_req;
  } req_word_t;

  typedef struct packed {
    logic [7:0] popped_id;
    status_t    status;
    logic [4:0] occupancy;
  } rsp_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_INS,
    S_RESP
  } state_t;

endpackage

// ----- hdl/rqpi_stream_if.sv -----
// Valid/ready channel carrying one word per handshake.
// Word type is a parameter; instances use the structs of rqpi_pkg.
interface rqpi_stream_if #(
  parameter type WORD_T = logic [0:0]
);
  logic  valid;
  logic  ready;
  WORD_T data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/rqpi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rqpi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hdl/ready_queue_priority_insert_core.sv -----
// Ready queue with priority insert: a bounded ordered queue of process ids,
// each stored with an unsigned priority code (lower value is served earlier).
// Depends on rqpi_pkg, rqpi_stream_if and rqpi_ram.
//
// Channels: req (sink) carries kind / process_id / priority_req; rsp
// (source) returns popped_id / status / occupancy, one word per req word.
//   append - write at the tail.
//   insert - place before the first entry whose priority is strictly
//            greater; equal priorities keep arrival order.
//   pop    - remove the head. Pop on empty, append or insert into full give
//            status codes and leave the queue untouched; kind 3 is a no-op.
// Entries live in one RAM used as a ring (head pointer + fill count).
// A no-op, a pop on empty or a drop on full goes from idle straight to the
// result state; a pop passes through S_POP; append and insert walk in S_INS,
// where for an insert the single read port streams through every entry while
// the write port shifts entries toward the tail. req.ready is high only while
// idle, so a word is taken only after the previous result loads; a stalled
// rsp holds its word and the next result waits for it. Reset (rst,
// synchronous) empties the queue; the RAM needs no clear, since only slots
// below the fill count are ever used.
module ready_queue_priority_insert_core #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  rqpi_stream_if.sink          req,
  rqpi_stream_if.source        rsp
);
  import rqpi_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = ID_BITS + PRIORITY_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // Logical slot (0 = head) to physical RAM address on the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h,
                                         input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(l);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return AW'(s);
  endfunction

  state_t state, state_next;

  // Queue bookkeeping
  logic [AW-1:0] head;
  logic [CW-1:0] count;

  // Current item
  logic [ID_BITS-1:0]       op_id;
  logic [PRIORITY_BITS-1:0] op_prio;

  // Insert walk: rk = next slot to read, wk = slot whose data returns now
  logic [CW-1:0] rk;
  logic [CW-1:0] wk;
  logic          pend;
  logic          placed;
  logic [EW-1:0] carry;

  rsp_word_t res;
  logic      rsp_valid;
  rsp_word_t rsp_data;

  // RAM port signals
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [EW-1:0]            ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [EW-1:0]            ram_rdata;
  logic [ID_BITS-1:0]       rd_id;
  logic [PRIORITY_BITS-1:0] rd_prio;

  logic accept;
  logic ins_done;
  logic rsp_free;
  logic rd_more;

  assign accept    = req.valid && req.ready;
  assign rsp_free  = !rsp_valid || rsp.ready;
  assign rd_more   = (rk < count);
  assign ins_done  = !pend && !rd_more;
  assign rd_id     = ram_rdata[EW-1:PRIORITY_BITS];
  assign rd_prio   = ram_rdata[PRIORITY_BITS-1:0];

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  rqpi_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.data.kind)
            KIND_APPEND, KIND_INSERT: begin
              state_next = (count == DEPTH_C) ? S_RESP : S_INS;
            end
            KIND_POP: begin
              state_next = (count == '0) ? S_RESP : S_POP;
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_POP:  state_next = S_RESP;
      S_INS: begin
        if (ins_done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: handshake and RAM access
  always_comb begin
    req.ready = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head;
    ram_we    = 1'b0;
    ram_waddr = phys(head, wk);
    ram_wdata = carry;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        ram_re    = req.valid;   // head read, used only by a pop
      end
      S_INS: begin
        ram_re    = rd_more;
        ram_raddr = phys(head, rk);
        if (pend) begin
          // Before the insert point nothing moves; from it on, each slot
          // takes the entry (or the new item) carried from the slot above.
          if (placed) begin
            ram_we = 1'b1;
          end else if (rd_prio > op_prio) begin
            ram_we    = 1'b1;
            ram_wdata = {op_id, op_prio};
          end
        end else if (!rd_more) begin
          // Tail write: displaced last entry, or the new item itself
          ram_we    = 1'b1;
          ram_waddr = phys(head, count);
          ram_wdata = placed ? carry : {op_id, op_prio};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      pend      <= 1'b0;
      placed    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Output register loads as the old word leaves or when empty
      if (state == S_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          pend   <= 1'b0;
          placed <= 1'b0;
        end
        S_POP: begin
          head  <= phys(head, CW'(1));
          count <= count - CW'(1);
        end
        S_INS: begin
          if (pend && (placed || rd_prio > op_prio)) begin
            placed <= 1'b1;
          end
          pend <= rd_more;
          if (ins_done) begin
            count <= count + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_id         <= ID_BITS'(req.data.process_id);
          op_prio       <= PRIORITY_BITS'(req.data.priority_req);
          rk            <= (req.data.kind == KIND_INSERT) ? '0 : count;
          res.popped_id <= '0;
          res.occupancy <= 5'(count);
          case (req.data.kind)
            KIND_APPEND, KIND_INSERT: begin
              res.status <= (count == DEPTH_C) ? ST_FULL : ST_DONE;
            end
            KIND_POP: begin
              res.status <= (count == '0) ? ST_EMPTY : ST_DONE;
            end
            default: res.status <= ST_DONE;
          endcase
        end
      end
      S_POP: begin
        res.popped_id <= 8'(rd_id);
        res.occupancy <= 5'(count - CW'(1));
      end
      S_INS: begin
        if (pend && (placed || rd_prio > op_prio)) begin
          carry <= ram_rdata;
        end
        if (rd_more) begin
          wk <= rk;
          rk <= rk + CW'(1);
        end
        if (ins_done) begin
          res.occupancy <= 5'(count + CW'(1));
        end
      end
      S_RESP: begin
        if (rsp_free) begin
          rsp_data <= res;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/rqpi_checker.sv -----
// Port-level checker for the ready queue core, bound into every core instance.
// Depends on rqpi_pkg and ready_queue_priority_insert_core_assert.svh.
`include "ready_queue_priority_insert_core_assert.svh"

module rqpi_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input rqpi_pkg::rsp_word_t rsp_data
);
  import rqpi_pkg::*;

  // A stalled result word stays put
  `RQPI_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

  // One word at a time: the core is busy right after taking one
  `RQPI_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)

  // A dropped append or insert only happens with the queue full
  `RQPI_ASSERT_IMPL(a_full_occ, clk, rst, rsp_valid && rsp_data.status == ST_FULL, rsp_data.occupancy == 5'(QUEUE_DEPTH))

  // Pop on empty returns nothing and leaves the queue empty
  `RQPI_ASSERT_IMPL(a_empty_pop, clk, rst, rsp_valid && rsp_data.status == ST_EMPTY, rsp_data.occupancy == '0 && rsp_data.popped_id == '0)

endmodule

bind ready_queue_priority_insert_core rqpi_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rqpi_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for ready_queue_priority_insert_core: drives req words, predicts each
// rsp word with a behavioral copy of the queue and compares field by field.
// Depends on rqpi_pkg, rqpi_stream_if and the core RTL.
module testbench;
  import rqpi_pkg::*;

  // Kind 3 has no name in the package; the core treats it as a no-op.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int DEPTH = 16;
  // Worst case: every word an insert into a near-full queue, plus sender
  // gaps and rsp stalls. Several times over that.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Inserts walk every entry held, so take longest; wait well past that at the end.
  localparam int TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rqpi_stream_if #(.WORD_T(req_word_t)) req_if ();
  rqpi_stream_if #(.WORD_T(rsp_word_t)) rsp_if ();

  ready_queue_priority_insert_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Behavioral queue: slot 0 is the head, only slots below the fill count
  // hold live entries.
  // ---------------------------------------------------------------------
  logic [7:0]  queue_ids   [DEPTH];
  logic [15:0] queue_prios [DEPTH];
  int          queue_fill;

  rsp_word_t   expected_results [$];
  int unsigned cycle_count;
  int          mismatch_count;
  int          words_sent;
  int          results_checked;
  int          full_drops;
  int          empty_pops;

  // Sender burst/gap bookkeeping.
  int burst_left;
  bit steady_send;

  // Apply one accepted req word to the behavioral queue and return the
  // rsp word the core should give for it.
  function automatic rsp_word_t predict_queue(req_word_t w);
    rsp_word_t r;
    int pos;
    int k;
    r.popped_id = '0;
    r.status    = ST_DONE;
    if (w.kind == KIND_APPEND || w.kind == KIND_INSERT) begin
      if (queue_fill >= DEPTH) begin
        r.status = ST_FULL;
        full_drops++;
      end else begin
        pos = queue_fill;
        // Stable insert: before the first strictly greater priority.
        if (w.kind == KIND_INSERT) begin
          for (k = 0; k < queue_fill; k++) begin
            if (queue_prios[k] > w.priority_req) begin
              pos = k;
              break;
            end
          end
        end
        for (k = queue_fill; k > pos; k--) begin
          queue_ids[k]   = queue_ids[k-1];
          queue_prios[k] = queue_prios[k-1];
        end
        queue_ids[pos]   = w.process_id;
        queue_prios[pos] = w.priority_req;
        queue_fill++;
      end
    end else if (w.kind == KIND_POP) begin
      if (queue_fill == 0) begin
        r.status = ST_EMPTY;
        empty_pops++;
      end else begin
        r.popped_id = queue_ids[0];
        for (k = 1; k < queue_fill; k++) begin
          queue_ids[k-1]   = queue_ids[k];
          queue_prios[k-1] = queue_prios[k];
        end
        queue_fill--;
      end
    end
    // Unused kind falls through: no change, status done.
    r.occupancy = 5'(queue_fill);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int want, input int got);
    mismatch_count++;
    $display("ERROR cycle %0d: %s expected %0d got %0d", cycle_count, field, want, got);
  endtask

  // Send one req word. Called and returns at a falling edge. The sender runs
  // in bursts; valid only drops when a gap is actually taken, so it is never
  // lowered and raised in the same step.
  task automatic send_word(input logic [1:0] kind, input logic [7:0] pid,
                           input logic [15:0] prio);
    req_word_t w;
    int gap;
    w.kind         = kind;
    w.process_id   = pid;
    w.priority_req = prio;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        steady_send = ~steady_send;
      end
      gap = steady_send ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    do @(posedge clk); while (!req_if.ready);
    expected_results.push_back(predict_queue(w));
    words_sent++;
    @(negedge clk);
  endtask

  // Half spread out, half from 0..7 to pile up ties and test stability.
  function automatic logic [15:0] random_priority();
    if ($urandom_range(0, 1) == 0) begin
      return 16'($urandom_range(0, 7));
    end
    return 16'($urandom);
  endfunction

  // Receiver pattern: successive phases rotate through always ready,
  // a fixed 2-of-5 duty, light random stalls and heavy random stalls.
  function automatic logic rsp_ready_pattern(int unsigned cyc);
    case ((cyc >> 8) % 4)
      0: return 1'b1;
      1: return (cyc % 5) < 2;
      2: return $urandom_range(0, 3) != 0;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(negedge clk) begin
    rsp_if.ready <= rsp_ready_pattern(cycle_count);
  end

  // Result checker: every accepted rsp word against the oldest prediction.
  always @(posedge clk) begin : check_rsp
    rsp_word_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected rsp word, occupancy", -1, int'(rsp_if.data.occupancy));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (rsp_if.data.popped_id !== want.popped_id) begin
          report_mismatch("popped_id", int'(want.popped_id), int'(rsp_if.data.popped_id));
        end
        if (rsp_if.data.status !== want.status) begin
          report_mismatch("status", int'(want.status), int'(rsp_if.data.status));
        end
        if (rsp_if.data.occupancy !== want.occupancy) begin
          report_mismatch("occupancy", int'(want.occupancy), int'(rsp_if.data.occupancy));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("ERROR: timeout after %0d cycles, %0d rsp words outstanding",
             cycle_count, expected_results.size());
    $display("ready_queue_priority_insert_core: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Pop on an empty queue and the unused kind, both with all-ones fields.
  task automatic test_empty_and_noop();
    send_word(KIND_POP, 8'hFF, 16'hFFFF);
    send_word(KIND_UNUSED, 8'hFF, 16'hFFFF);
  endtask

  // Fill to the brim with extreme and tied priorities, mixing appends into
  // the inserts, then try both enqueue kinds on a full queue and pop a few.
  task automatic test_fill_overflow();
    logic [15:0] prio;
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: prio = 16'h8000;
        1: prio = 16'h0000;
        2: prio = 16'hFFFF;
        default: prio = 16'h8000;
      endcase
      send_word((i % 5 == 0) ? KIND_APPEND : KIND_INSERT, 8'(i * 17), prio);
    end
    send_word(KIND_APPEND, 8'h00, 16'h0000);
    send_word(KIND_INSERT, 8'hFF, 16'h0000);
    repeat (3) send_word(KIND_POP, 8'h00, 16'h0000);
  endtask

  // Free-running mix; enqueues slightly outweigh pops, so the queue wanders
  // from empty to full and back.
  task automatic test_random_mix(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_word(KIND_INSERT, 8'($urandom), random_priority());
      end else if (pick < 55) begin
        send_word(KIND_APPEND, 8'($urandom), random_priority());
      end else if (pick < 95) begin
        send_word(KIND_POP, 8'($urandom), 16'($urandom));
      end else begin
        send_word(KIND_UNUSED, 8'($urandom), 16'($urandom));
      end
    end
  endtask

  // Whole fill/drain rounds: mostly inserts, sometimes overfilled, then
  // drained to empty with an occasional extra pop on the empty queue.
  task automatic test_fill_drain(input int rounds);
    int fill_len;
    int drain_len;
    repeat (rounds) begin
      fill_len = $urandom_range(6, DEPTH + 2);
      repeat (fill_len) begin
        send_word(($urandom_range(0, 3) == 0) ? KIND_APPEND : KIND_INSERT,
                  8'($urandom), random_priority());
      end
      drain_len = queue_fill + $urandom_range(0, 1);
      repeat (drain_len) send_word(KIND_POP, 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    rsp_if.ready   = 1'b0;
    cycle_count    = 0;
    mismatch_count = 0;
    words_sent     = 0;
    results_checked = 0;
    full_drops     = 0;
    empty_pops     = 0;
    queue_fill     = 0;
    burst_left     = 0;
    steady_send    = 1'b0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_and_noop();
    test_fill_overflow();
    test_random_mix(800);
    test_fill_drain(22);

    req_if.valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d req words, %0d rsp words checked in %0d cycles",
             words_sent, results_checked, cycle_count);
    $display("     %0d enqueues dropped on full, %0d pops on empty, %0d field errors",
             full_drops, empty_pops, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ready_queue_priority_insert_core: match");
    end else begin
      $display("ready_queue_priority_insert_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- ready_queue_priority_insert_core.f -----
+incdir+hdl
hdl/rqpi_pkg.sv
hdl/rqpi_stream_if.sv
hdl/rqpi_ram.sv
hdl/ready_queue_priority_insert_core.sv
hdl/rqpi_checker.sv
bench/testbench.sv
